// ----- rtl/core/ect_pkg.sv -----
`timescale 1ns / 1ps
package ect_pkg;

  localparam int MAP_BITS = 7;
  localparam int MAP_SIZE = 1 << MAP_BITS;
  localparam int ADDR_BITS = 2 * MAP_BITS;
  localparam int NUM_CLUSTERS = 5;
  localparam int SLOT_BITS = 3;
  localparam int ACC_BITS = 22;
  localparam logic [7:0] MAP_INIT = 8'd128;
  localparam logic [19:0] SUM_MAX = 20'hFFFFF;
  localparam logic [15:0] RECIP_TEN = 16'd52429;

  localparam logic [1:0] REG_BOX_HALF = 2'd0;
  localparam logic [1:0] REG_SPAWN_THR = 2'd1;
  localparam logic [1:0] REG_KILL_LIMIT = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic [2:0] RPT_NONE = 3'd0;
  localparam logic [2:0] RPT_MOVED = 3'd1;
  localparam logic [2:0] RPT_SPAWNED = 3'd2;
  localparam logic [2:0] RPT_INACTIVE = 3'd3;
  localparam logic [2:0] RPT_KEPT = 3'd4;
  localparam logic [2:0] RPT_KILLED = 3'd5;

  typedef enum logic [15:0] {
    S_CLR       = 16'h0001,
    S_IDLE      = 16'h0002,
    S_EV_RD     = 16'h0004,
    S_EV_WR     = 16'h0008,
    S_SCAN      = 16'h0010,
    S_SP_RD     = 16'h0020,
    S_SP_CHK    = 16'h0040,
    S_MUL       = 16'h0080,
    S_ADJ       = 16'h0100,
    S_OUT       = 16'h0200,
    S_MG_SLOT   = 16'h0400,
    S_MG_SUM    = 16'h0800,
    S_MG_DRAIN  = 16'h1000,
    S_MG_DEC    = 16'h2000,
    S_DECAY     = 16'h4000,
    S_DECAY_END = 16'h8000
  } state_t;

  function automatic logic [7:0] half_even(input logic [7:0] v);
    logic [7:0] h;
    h = {1'b0, v[7:1]};
    if (v[0] && h[0]) h = h + 8'd1;
    return h;
  endfunction

  function automatic logic [MAP_BITS-1:0] clamp_step(input logic [MAP_BITS-1:0] p,
                                                     input logic [1:0] k);
    logic [MAP_BITS:0] t;
    t = {1'b0, p} + {{(MAP_BITS-1){1'b0}}, k};
    if (t == '0) return '0;
    t = t - 1'b1;
    if (t[MAP_BITS]) return {MAP_BITS{1'b1}};
    return t[MAP_BITS-1:0];
  endfunction

endpackage

// ----- rtl/core/ect_ram.sv -----
`timescale 1ns / 1ps
module ect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/event_cluster_tracker.sv -----
`timescale 1ns / 1ps
// Tracks up to five clusters of event activity on a 128x128 map of 8-bit
// counts held in one single-port-write, registered-read RAM. After reset the
// block clears the whole map before it takes the first request. A pixel
// event does a read-modify-write over its neighbourhood, then slot compares,
// then a spawn check or a centre move through the shared divide-by-ten
// multiplier, plus the output handshake. A packet end that starts no pass
// only advances the packet counter. A management pass handles each slot in
// turn: it sums the clamped box of an active slot, reports an inactive one,
// and waits for an output handshake per slot; then the map decays.
module event_cluster_tracker
  import ect_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [6:0]  pixel_x,
  input  logic [6:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  report_code,
  output logic [2:0]  slot_index,
  output logic [14:0] centre_x,
  output logic [14:0] centre_y,
  output logic [19:0] box_sum,
  output logic        last
);

  logic [5:0]  box_half_size;
  logic [7:0]  spawn_threshold;
  logic [19:0] kill_sum_limit;
  logic [7:0]  manage_period;

  state_t state;
  logic [14:0] cx [NUM_CLUSTERS];
  logic [14:0] cy [NUM_CLUSTERS];
  logic [NUM_CLUSTERS-1:0] act;
  logic [7:0]  pc;
  logic [6:0]  ex, ey;
  logic [1:0]  nx, ny;
  logic [SLOT_BITS-1:0] slot;
  logic        axis, neg, mgmt;
  logic [31:0] prod;
  logic [ACC_BITS-1:0] acc;
  logic        rd_v;
  logic [6:0]  row, col, bx1, bx2m, by2m;
  logic [ADDR_BITS-1:0] dcnt, dwaddr;
  logic        dv;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  ect_ram #(.WIDTH(8), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [ADDR_BITS-1:0] ev_addr;
  assign ev_addr = {clamp_step(ey, ny), clamp_step(ex, nx)};

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ev_addr;
    ram_wdata = ram_rdata + 8'd2;
    ram_raddr = ev_addr;
    case (state)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = dcnt;
        ram_wdata = MAP_INIT;
      end
      S_EV_WR: ram_we = 1'b1;
      S_SP_RD: ram_raddr = {ey, ex};
      S_MG_SUM: ram_raddr = {row, col};
      S_DECAY, S_DECAY_END: begin
        ram_we = dv;
        ram_waddr = dwaddr;
        ram_wdata = half_even(ram_rdata);
        ram_raddr = dcnt;
      end
      default: ;
    endcase
  end

  // slot compare and first free slot
  logic [15:0] xs, ys, hs, cxs, cys;
  logic        hit;
  logic        any_free;
  logic [SLOT_BITS-1:0] free_slot;

  assign xs  = {1'b0, ex, 8'd0};
  assign ys  = {1'b0, ey, 8'd0};
  assign hs  = {2'b0, box_half_size, 8'd0};
  assign cxs = {1'b0, cx[slot]};
  assign cys = {1'b0, cy[slot]};
  assign hit = act[slot] && (xs < cxs + hs) && (xs + hs > cxs) &&
               (ys < cys + hs) && (ys + hs > cys);

  always_comb begin
    any_free = 1'b0;
    free_slot = '0;
    for (int i = NUM_CLUSTERS - 1; i >= 0; i--) begin
      if (!act[i]) begin
        any_free = 1'b1;
        free_slot = SLOT_BITS'(i);
      end
    end
  end

  // shared divide-by-ten step
  logic [14:0] c_sel;
  logic [6:0]  p_sel;
  logic [16:0] d;
  logic [15:0] mag;
  logic [12:0] q;
  logic [14:0] moved;

  assign c_sel = axis ? cy[slot] : cx[slot];
  assign p_sel = axis ? ey : ex;
  assign d     = {2'b0, p_sel, 8'd0} - {2'b0, c_sel};
  assign mag   = d[16] ? 16'(-d) : d[15:0];
  assign q     = prod[31:19];
  assign moved = neg ? c_sel - {2'b0, q} : c_sel + {2'b0, q};

  // management box bounds
  logic [6:0] fx, fy, x1, x2, y1, y2;
  logic [7:0] sx, sy;
  assign fx = cx[slot][14:8];
  assign fy = cy[slot][14:8];
  assign sx = {1'b0, fx} + {2'b0, box_half_size};
  assign sy = {1'b0, fy} + {2'b0, box_half_size};
  assign x1 = ({1'b0, fx} < {2'b0, box_half_size}) ? 7'd0 : 7'(fx - box_half_size);
  assign y1 = ({1'b0, fy} < {2'b0, box_half_size}) ? 7'd0 : 7'(fy - box_half_size);
  assign x2 = sx[7] ? 7'd127 : sx[6:0];
  assign y2 = sy[7] ? 7'd127 : sy[6:0];

  logic [7:0] pc_next;
  logic [19:0] sum_sat;
  assign pc_next = pc + 8'd1;
  assign sum_sat = (acc > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc[19:0];

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_half_size <= 6'd8;
      spawn_threshold <= 8'd20;
      kill_sum_limit <= 20'd1500;
      manage_period <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_HALF:   box_half_size <= cfg_data[5:0];
        REG_SPAWN_THR:  spawn_threshold <= cfg_data[7:0];
        REG_KILL_LIMIT: kill_sum_limit <= cfg_data;
        REG_PERIOD:     manage_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      dcnt <= '0;
      dv <= 1'b0;
      act <= '0;
      pc <= '0;
      out_valid <= 1'b0;
      rd_v <= 1'b0;
      mgmt <= 1'b0;
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        cx[i] <= '0;
        cy[i] <= '0;
      end
    end else begin
      rd_v <= (state == S_MG_SUM);
      if (rd_v) acc <= acc + {{(ACC_BITS-8){1'b0}}, ram_rdata};
      case (state)
        S_CLR: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == {ADDR_BITS{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            ex <= pixel_x;
            ey <= pixel_y;
            nx <= 2'd0;
            ny <= 2'd0;
            if (!operation) begin
              mgmt <= 1'b0;
              state <= S_EV_RD;
            end else if (pc_next >= manage_period) begin
              pc <= '0;
              mgmt <= 1'b1;
              slot <= '0;
              state <= S_MG_SLOT;
            end else begin
              pc <= pc_next;
            end
          end
        end
        S_EV_RD: state <= S_EV_WR;
        S_EV_WR: begin
          if (nx == 2'd2) begin
            nx <= 2'd0;
            if (ny == 2'd2) begin
              slot <= '0;
              state <= S_SCAN;
            end else begin
              ny <= ny + 2'd1;
              state <= S_EV_RD;
            end
          end else begin
            nx <= nx + 2'd1;
            state <= S_EV_RD;
          end
        end
        S_SCAN: begin
          if (hit) begin
            axis <= 1'b0;
            state <= S_MUL;
          end else if (slot == SLOT_BITS'(NUM_CLUSTERS - 1)) begin
            if (any_free) begin
              slot <= free_slot;
              state <= S_SP_RD;
            end else begin
              report_code <= RPT_NONE;
              slot_index <= '0;
              centre_x <= '0;
              centre_y <= '0;
              box_sum <= '0;
              last <= 1'b1;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_SP_RD: state <= S_SP_CHK;
        S_SP_CHK: begin
          box_sum <= '0;
          last <= 1'b1;
          out_valid <= 1'b1;
          state <= S_OUT;
          if (ram_rdata > spawn_threshold) begin
            act[slot] <= 1'b1;
            cx[slot] <= {ex, 8'd0};
            cy[slot] <= {ey, 8'd0};
            report_code <= RPT_SPAWNED;
            slot_index <= slot;
            centre_x <= {ex, 8'd0};
            centre_y <= {ey, 8'd0};
          end else begin
            report_code <= RPT_NONE;
            slot_index <= '0;
            centre_x <= '0;
            centre_y <= '0;
          end
        end
        S_MUL: begin
          prod <= 32'(({16'd0, mag} + 32'd5) * {16'd0, RECIP_TEN});
          neg <= d[16];
          state <= S_ADJ;
        end
        S_ADJ: begin
          if (axis) begin
            cy[slot] <= moved;
            report_code <= RPT_MOVED;
            slot_index <= slot;
            centre_x <= cx[slot];
            centre_y <= moved;
            box_sum <= '0;
            last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            cx[slot] <= moved;
            axis <= 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (!mgmt) begin
              state <= S_IDLE;
            end else if (slot == SLOT_BITS'(NUM_CLUSTERS - 1)) begin
              dcnt <= '0;
              dv <= 1'b0;
              state <= S_DECAY;
            end else begin
              slot <= slot + 1'b1;
              state <= S_MG_SLOT;
            end
          end
        end
        S_MG_SLOT: begin
          acc <= '0;
          if (!act[slot]) begin
            report_code <= RPT_INACTIVE;
            slot_index <= slot;
            centre_x <= '0;
            centre_y <= '0;
            box_sum <= '0;
            last <= (slot == SLOT_BITS'(NUM_CLUSTERS - 1));
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (x1 >= x2 || y1 >= y2) begin
            state <= S_MG_DEC;
          end else begin
            row <= y1;
            col <= x1;
            bx1 <= x1;
            bx2m <= x2 - 7'd1;
            by2m <= y2 - 7'd1;
            state <= S_MG_SUM;
          end
        end
        S_MG_SUM: begin
          if (col == bx2m) begin
            col <= bx1;
            row <= row + 7'd1;
            if (row == by2m) state <= S_MG_DRAIN;
          end else begin
            col <= col + 7'd1;
          end
        end
        S_MG_DRAIN: state <= S_MG_DEC;
        S_MG_DEC: begin
          slot_index <= slot;
          centre_x <= cx[slot];
          centre_y <= cy[slot];
          box_sum <= sum_sat;
          last <= (slot == SLOT_BITS'(NUM_CLUSTERS - 1));
          out_valid <= 1'b1;
          state <= S_OUT;
          if (sum_sat < kill_sum_limit) begin
            act[slot] <= 1'b0;
            report_code <= RPT_KILLED;
          end else begin
            report_code <= RPT_KEPT;
          end
        end
        S_DECAY: begin
          dv <= 1'b1;
          dwaddr <= dcnt;
          dcnt <= dcnt + 1'b1;
          if (dcnt == {ADDR_BITS{1'b1}}) state <= S_DECAY_END;
        end
        S_DECAY_END: begin
          dv <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("request taken while a result is pending");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (report_code <= RPT_KILLED))
    else $error("report code out of range");

  a_pass_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_code >= RPT_INACTIVE) |->
      (last == (slot_index == SLOT_BITS'(NUM_CLUSTERS - 1))))
    else $error("last flag wrong on management report");

  a_kill_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_MG_DEC && sum_sat < kill_sum_limit) |=> !act[slot_index])
    else $error("killed slot still active");

endmodule

// ----- dv/tb_event_cluster_tracker.sv -----
`timescale 1ns / 1ps
module tb_event_cluster_tracker;
  import ect_pkg::*;

  typedef struct packed {
    logic [2:0]  code;
    logic [2:0]  slot;
    logic [14:0] cx;
    logic [14:0] cy;
    logic [19:0] sum;
    logic        fin;
  } report_t;

  typedef struct packed {
    logic       op;
    logic [6:0] x;
    logic [6:0] y;
    logic       typed;
    report_t    rpt;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = 1'b0;
  logic [6:0]  pixel_x = '0;
  logic [6:0]  pixel_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  report_code;
  logic [2:0]  slot_index;
  logic [14:0] centre_x;
  logic [14:0] centre_y;
  logic [19:0] box_sum;
  logic        last;

  event_cluster_tracker u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .out_valid(out_valid), .out_ready(out_ready),
    .report_code(report_code), .slot_index(slot_index), .centre_x(centre_x),
    .centre_y(centre_y), .box_sum(box_sum), .last(last)
  );

  always #5 clk = ~clk;

  // tracker shadow state
  logic [7:0]  trk_map[MAP_SIZE*MAP_SIZE];
  logic [14:0] trk_cx[NUM_CLUSTERS];
  logic [14:0] trk_cy[NUM_CLUSTERS];
  logic        trk_act[NUM_CLUSTERS];
  logic [7:0]  trk_pkt;
  int          half_w, spawn_thr, kill_lim, period;

  report_t     report_q[$];
  int          errors = 0;
  bit          fast_in = 0;
  bit          fast_out = 0;
  bit          hold_req = 0;

  function automatic int clamp_px(int v);
    if (v < 0) return 0;
    if (v > MAP_SIZE - 1) return MAP_SIZE - 1;
    return v;
  endfunction

  function automatic logic [14:0] step_tenth(logic [14:0] c, int pos);
    int d, m, q, r;
    d = pos * 256 - int'(c);
    m = (d < 0) ? -d : d;
    q = (m + 5) / 10;
    r = int'(c) + ((d < 0) ? -q : q);
    if (r < 0) r = 0;
    if (r > 32767) r = 32767;
    return r[14:0];
  endfunction

  function automatic logic [19:0] box_activity(logic [14:0] cx, logic [14:0] cy);
    int x1, x2, y1, y2;
    longint s;
    x1 = clamp_px(int'(cx >> 8) - half_w);
    x2 = clamp_px(int'(cx >> 8) + half_w);
    y1 = clamp_px(int'(cy >> 8) - half_w);
    y2 = clamp_px(int'(cy >> 8) + half_w);
    s = 0;
    for (int r = y1; r < y2; r++)
      for (int c = x1; c < x2; c++)
        s += trk_map[r*MAP_SIZE + c];
    if (s > 1048575) s = 1048575;
    return s[19:0];
  endfunction

  task automatic track_request(logic op, logic [6:0] px, logic [6:0] py);
    int x, y, xs, ys, hs, cx, cy, free;
    report_t r;
    logic [19:0] s;
    logic [7:0] v;
    x = px; y = py;
    xs = x * 256; ys = y * 256; hs = half_w * 256;
    if (!op) begin
      for (int dx = -1; dx <= 1; dx++)
        for (int dy = -1; dy <= 1; dy++)
          trk_map[clamp_px(y+dy)*MAP_SIZE + clamp_px(x+dx)] += 8'd2;
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
        cx = trk_cx[i]; cy = trk_cy[i];
        if (trk_act[i] && xs < cx + hs && xs > cx - hs && ys < cy + hs && ys > cy - hs) begin
          trk_cx[i] = step_tenth(trk_cx[i], x);
          trk_cy[i] = step_tenth(trk_cy[i], y);
          report_q.push_back('{RPT_MOVED, i[2:0], trk_cx[i], trk_cy[i], 20'd0, 1'b1});
          return;
        end
      end
      free = -1;
      for (int i = NUM_CLUSTERS - 1; i >= 0; i--)
        if (!trk_act[i]) free = i;
      v = trk_map[y*MAP_SIZE + x];
      if (free >= 0 && v > spawn_thr) begin
        trk_act[free] = 1'b1;
        trk_cx[free] = xs[14:0];
        trk_cy[free] = ys[14:0];
        report_q.push_back('{RPT_SPAWNED, free[2:0], xs[14:0], ys[14:0], 20'd0, 1'b1});
      end else begin
        report_q.push_back('{RPT_NONE, 3'd0, 15'd0, 15'd0, 20'd0, 1'b1});
      end
      return;
    end
    trk_pkt = trk_pkt + 8'd1;
    if (trk_pkt < period) return;
    trk_pkt = '0;
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      r.slot = i[2:0];
      r.fin = (i == NUM_CLUSTERS - 1);
      if (!trk_act[i]) begin
        r.code = RPT_INACTIVE; r.cx = '0; r.cy = '0; r.sum = '0;
      end else begin
        s = box_activity(trk_cx[i], trk_cy[i]);
        r.cx = trk_cx[i]; r.cy = trk_cy[i]; r.sum = s;
        if (s < kill_lim) begin
          trk_act[i] = 1'b0;
          r.code = RPT_KILLED;
        end else begin
          r.code = RPT_KEPT;
        end
      end
      report_q.push_back(r);
    end
    for (int i = 0; i < MAP_SIZE*MAP_SIZE; i++) begin
      v = {1'b0, trk_map[i][7:1]};
      if (trk_map[i][0] && v[0]) v = v + 8'd1;
      trk_map[i] = v;
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_BOX_HALF:   half_w = val[5:0];
      REG_SPAWN_THR:  spawn_thr = val[7:0];
      REG_KILL_LIMIT: kill_lim = val;
      REG_PERIOD:     period = val[7:0];
      default: ;
    endcase
  endtask

  task automatic send_request(logic op, logic [6:0] px, logic [6:0] py,
                              logic typed, report_t rpt);
    int gap;
    gap = fast_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1; operation = op; pixel_x = px; pixel_y = py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_request(op, px, py);
    if (typed) begin
      void'(report_q.pop_back());
      report_q.push_back(rpt);
    end
    @(negedge clk);
  endtask

  task automatic send_random(int pkt_odds);
    int s, x, y;
    report_t none;
    none = '0;
    if ($urandom_range(0, pkt_odds - 1) == 0) begin
      send_request(1'b1, 7'($urandom), 7'($urandom), 1'b0, none);
    end else begin
      s = $urandom_range(0, NUM_CLUSTERS - 1);
      if (trk_act[s] && $urandom_range(0, 9) < 6) begin
        x = clamp_px(int'(trk_cx[s] >> 8) + $urandom_range(0, 2*half_w) - half_w);
        y = clamp_px(int'(trk_cy[s] >> 8) + $urandom_range(0, 2*half_w) - half_w);
      end else begin
        x = $urandom_range(0, 127);
        y = $urandom_range(0, 127);
      end
      send_request(1'b0, x[6:0], y[6:0], 1'b0, none);
    end
  endtask

  task automatic drain_block();
    in_valid = 1'b0;
    while (report_q.size() > 0) @(negedge clk);
    repeat (17000) @(negedge clk);
  endtask

  task automatic set_regs(int h, int thr, int kl, int per);
    write_reg(REG_BOX_HALF, h[19:0]);
    write_reg(REG_SPAWN_THR, thr[19:0]);
    write_reg(REG_KILL_LIMIT, kl[19:0]);
    write_reg(REG_PERIOD, per[19:0]);
  endtask

  dir_row_t dir_tab[] = '{
    '{1'b0, 7'd0,   7'd0,   1'b1, '{RPT_SPAWNED, 3'd0, 15'd0, 15'd0, 20'd0, 1'b1}},
    '{1'b0, 7'd127, 7'd127, 1'b1, '{RPT_SPAWNED, 3'd1, 15'd32512, 15'd32512, 20'd0, 1'b1}},
    '{1'b0, 7'd1,   7'd1,   1'b1, '{RPT_MOVED, 3'd0, 15'd26, 15'd26, 20'd0, 1'b1}},
    '{1'b0, 7'd127, 7'd0,   1'b1, '{RPT_SPAWNED, 3'd2, 15'd32512, 15'd0, 20'd0, 1'b1}},
    '{1'b0, 7'd0,   7'd127, 1'b1, '{RPT_SPAWNED, 3'd3, 15'd0, 15'd32512, 20'd0, 1'b1}},
    '{1'b0, 7'd64,  7'd64,  1'b1, '{RPT_SPAWNED, 3'd4, 15'd16384, 15'd16384, 20'd0, 1'b1}},
    '{1'b0, 7'd32,  7'd32,  1'b1, '{RPT_NONE, 3'd0, 15'd0, 15'd0, 20'd0, 1'b1}},
    '{1'b0, 7'd120, 7'd126, 1'b0, '0},
    '{1'b0, 7'd70,  7'd58,  1'b0, '0},
    '{1'b0, 7'd85,  7'd42,  1'b0, '0},
    '{1'b0, 7'd42,  7'd85,  1'b0, '0},
    '{1'b1, 7'd0,   7'd0,   1'b0, '0},
    '{1'b1, 7'd127, 7'd127, 1'b0, '0},
    '{1'b1, 7'd85,  7'd42,  1'b0, '0},
    '{1'b0, 7'd64,  7'd64,  1'b0, '0},
    '{1'b0, 7'd66,  7'd62,  1'b0, '0},
    '{1'b0, 7'd3,   7'd124, 1'b0, '0},
    '{1'b0, 7'd126, 7'd2,   1'b0, '0},
    '{1'b1, 7'd1,   7'd1,   1'b0, '0},
    '{1'b1, 7'd2,   7'd2,   1'b0, '0},
    '{1'b1, 7'd3,   7'd3,   1'b0, '0}
  };

  initial begin
    for (int i = 0; i < MAP_SIZE*MAP_SIZE; i++) trk_map[i] = MAP_INIT;
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      trk_cx[i] = '0; trk_cy[i] = '0; trk_act[i] = 1'b0;
    end
    trk_pkt = '0;
    half_w = 8; spawn_thr = 20; kill_lim = 1500; period = 3;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    // hold off until the map clear is over
    repeat (16500) @(negedge clk);
    set_regs(8, 20, 1500, 3);
    foreach (dir_tab[i])
      send_request(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].typed, dir_tab[i].rpt);
    drain_block();

    set_regs(1, 0, 0, 2);
    for (int i = 0; i < 50; i++) begin
      if (i == 20) hold_req = 1;
      send_random(10);
    end
    drain_block();

    fast_in = 1; fast_out = 1;
    set_regs(32, 255, 1048575, 1);
    for (int i = 0; i < 30; i++) send_random(15);
    drain_block();

    fast_in = 0; fast_out = 0;
    set_regs(5, 100, 20000, 2);
    for (int i = 0; i < 50; i++) begin
      if (i == 25) begin
        in_valid = 1'b0;
        while (report_q.size() > 0) @(negedge clk);
      end
      send_random(10);
    end
    drain_block();

    fast_out = 1;
    set_regs(12, 60, 3000, 4);
    for (int i = 0; i < 50; i++) send_random(8);
    drain_block();

    fast_out = 0;
    set_regs(3, 130, 200, 255);
    for (int i = 0; i < 59; i++) send_random(12);
    in_valid = 1'b0;
    while (report_q.size() > 0) @(negedge clk);
    repeat (17000) @(negedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready = 1'b0;
        repeat (4000) @(negedge clk);
      end
      gap = fast_out ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%t unexpected report code %0d slot %0d", $time, report_code, slot_index);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (report_code !== want.code) begin
          $display("%t report_code exp %0d got %0d", $time, want.code, report_code);
          errors++;
        end
        if (slot_index !== want.slot) begin
          $display("%t slot_index exp %0d got %0d", $time, want.slot, slot_index);
          errors++;
        end
        if (centre_x !== want.cx) begin
          $display("%t centre_x exp %0d got %0d", $time, want.cx, centre_x);
          errors++;
        end
        if (centre_y !== want.cy) begin
          $display("%t centre_y exp %0d got %0d", $time, want.cy, centre_y);
          errors++;
        end
        if (box_sum !== want.sum) begin
          $display("%t box_sum exp %0d got %0d", $time, want.sum, box_sum);
          errors++;
        end
        if (last !== want.fin) begin
          $display("%t last exp %0d got %0d", $time, want.fin, last);
          errors++;
        end
      end
    end
  end

  initial begin
    #500_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
